/* hw/rtl/hsv2rgb_pkg.sv */
// Shared types and constants for the HSV to RGB pixel converter.
package hsv2rgb_pkg;

	localparam int FRAC_BITS = 16;
	localparam int FRAC_W    = FRAC_BITS + 1;

	typedef logic [FRAC_W-1:0] frac_t;
	typedef logic [7:0]        chan8_t;

	localparam frac_t FRAC_ONE = frac_t'(1) << FRAC_BITS;

	// Clamped saturation and value plus the three channel fractions of one pixel.
	typedef struct packed {
		frac_t sat;
		frac_t bri;
		frac_t red;
		frac_t grn;
		frac_t blu;
	} hsv_frac_t;

endpackage

/* hw/rtl/hsv_to_rgb_pixel_core.sv */
// Top level of the fixed-point HSV to RGB pixel converter.
//
// Usage:
//   Input channel (in_valid/in_ready) carries hue, saturation and brightness as
//   unsigned 1.16 fractions; output channel (out_valid/out_ready) carries 8-bit
//   red, green and blue. Every input transfer yields exactly one output transfer.
//   Hue above one turn wraps; saturation and brightness above one clamp to one.
// Pipeline: four stages from input transfer to out_valid (sector select,
//   blend product, value product, scale by 255).
// Throughput: one pixel per clock unless stalled; the pipeline advances as a whole.
// Stall: while out_valid is high and out_ready low, the whole pipeline holds and
//   in_ready drops; nothing is lost or repeated. Bubbles in flight stay in place.
// Reset: arst_n clears all stage valid bits asynchronously; data registers are
//   not reset. No configuration, no state beyond the pipeline.
module hsv_to_rgb_pixel_core
	import hsv2rgb_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	input  frac_t  hue,
	input  frac_t  saturation,
	input  frac_t  brightness,
	output logic   out_valid,
	input  logic   out_ready,
	output chan8_t red,
	output chan8_t green,
	output chan8_t blue
);

	hsv_frac_t frac;
	hsv_frac_t frac_s1;
	logic      valid_s1;
	logic      valid_s2;
	logic      valid_s3;
	logic      valid_s4;
	logic      en;

	// advance everything unless a finished pixel is waiting on the receiver
	assign en       = !valid_s4 || out_ready;
	assign in_ready = en;

	hsv2rgb_sector u_sector (
		.hue        (hue),
		.saturation (saturation),
		.brightness (brightness),
		.frac       (frac)
	);

	// stage 1: hold the sector result
	always_ff @(posedge clk) begin
		if (en) begin
			frac_s1 <= frac;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// stages 2 to 4: one mixer per channel
	hsv2rgb_mix u_mix_red (
		.clk   (clk),
		.en    (en),
		.chan  (frac_s1.red),
		.sat   (frac_s1.sat),
		.bri   (frac_s1.bri),
		.pixel (red)
	);

	hsv2rgb_mix u_mix_green (
		.clk   (clk),
		.en    (en),
		.chan  (frac_s1.grn),
		.sat   (frac_s1.sat),
		.bri   (frac_s1.bri),
		.pixel (green)
	);

	hsv2rgb_mix u_mix_blue (
		.clk   (clk),
		.en    (en),
		.chan  (frac_s1.blu),
		.sat   (frac_s1.sat),
		.bri   (frac_s1.bri),
		.pixel (blue)
	);

	assign out_valid = valid_s4;

	// an input transfer always lands in stage 1
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> valid_s1)
		else $error("accepted pixel missing from stage 1");

	// a stalled output freezes every stage in flight
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable({valid_s1, valid_s2, valid_s3}) && out_valid)
		else $error("pipeline moved during output stall");

	// a new output pixel must come from stage 3
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(valid_s3))
		else $error("output valid without a pixel in stage 3");

	// a drained pipeline stays empty without input
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		!in_valid && !valid_s1 && !valid_s2 && !valid_s3 && en |=> !valid_s1 && !valid_s4)
		else $error("pixel appeared from nothing");

endmodule

/* hw/rtl/hsv2rgb_sector.sv */
// Hue wrap, sector selection and saturation/value clamping.
module hsv2rgb_sector
	import hsv2rgb_pkg::*;
(
	input  frac_t     hue,
	input  frac_t     saturation,
	input  frac_t     brightness,
	output hsv_frac_t frac
);

	localparam int T_W = FRAC_W + 2;
	localparam logic [T_W-1:0] ONE_T = T_W'(FRAC_ONE);

	frac_t          h;
	logic [T_W-1:0] t;

	always_comb begin
		h = (hue > FRAC_ONE) ? {1'b0, hue[FRAC_BITS-1:0]} : hue;
		t = {h, 2'b00} + {1'b0, h, 1'b0};

		frac.sat = (saturation > FRAC_ONE) ? FRAC_ONE : saturation;
		frac.bri = (brightness > FRAC_ONE) ? FRAC_ONE : brightness;
		frac.red = '0;
		frac.grn = '0;
		frac.blu = '0;

		if (t <= ONE_T) begin
			frac.red = FRAC_ONE;
			frac.grn = t[FRAC_W-1:0];
		end else if (t <= 2 * ONE_T) begin
			frac.grn = FRAC_ONE;
			frac.red = FRAC_W'(2 * ONE_T - t);
		end else if (t <= 3 * ONE_T) begin
			frac.grn = FRAC_ONE;
			frac.blu = FRAC_W'(t - 2 * ONE_T);
		end else if (t <= 4 * ONE_T) begin
			frac.blu = FRAC_ONE;
			frac.grn = FRAC_W'(4 * ONE_T - t);
		end else if (t <= 5 * ONE_T) begin
			frac.blu = FRAC_ONE;
			frac.red = FRAC_W'(t - 4 * ONE_T);
		end else begin
			frac.red = FRAC_ONE;
			frac.blu = FRAC_W'(6 * ONE_T - t);
		end
	end

endmodule

/* hw/rtl/hsv2rgb_mix.sv */
// Three-stage channel mixer: saturation blend, value scale, times 255.
module hsv2rgb_mix
	import hsv2rgb_pkg::*;
(
	input  logic   clk,
	input  logic   en,
	input  frac_t  chan,
	input  frac_t  sat,
	input  frac_t  bri,
	output chan8_t pixel
);

	localparam int D_W  = 2 * FRAC_BITS + 1;
	localparam int MV_W = D_W + FRAC_BITS;
	localparam int P_W  = MV_W + 8;
	localparam logic [D_W-1:0] ONE_SQ = D_W'(1) << (2 * FRAC_BITS);

	frac_t             rem;
	logic [2*FRAC_W-1:0] dprod;
	logic [D_W-1:0]    m;
	logic [MV_W-1:0]   mprod;
	logic [P_W-1:0]    p;

	logic [D_W-1:0]    d_s2;
	frac_t             bri_s2;
	logic [MV_W-1:0]   mv_s3;
	chan8_t            pixel_s4;

	// m = s*c + (1-s)*1 rewritten as 1 - s*(1-c)
	always_comb begin
		rem   = FRAC_ONE - chan;
		dprod = {{FRAC_W{1'b0}}, sat} * {{FRAC_W{1'b0}}, rem};
		m     = ONE_SQ - d_s2;
		mprod = {{(MV_W-D_W){1'b0}}, m} * {{(MV_W-FRAC_W){1'b0}}, bri_s2};
		p     = {mv_s3, 8'b0} - {8'b0, mv_s3};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s2     <= dprod[D_W-1:0];
			bri_s2   <= bri;
			mv_s3    <= mprod;
			pixel_s4 <= p[MV_W+7-1:MV_W-1];
		end
	end

	assign pixel = pixel_s4;

endmodule

/* dv/tb_hsv_to_rgb_pixel_core.sv */
// Self-checking testbench for the HSV to RGB pixel converter.
`timescale 1ns / 1ps

module tb_hsv_to_rgb_pixel_core
	import hsv2rgb_pkg::*;
();

	// One expected output pixel.
	typedef struct packed {
		chan8_t r;
		chan8_t g;
		chan8_t b;
	} rgb_t;

	localparam logic [63:0] UNIT      = 64'd65536;
	localparam frac_t       FRAC_MAX  = '1;
	localparam int          HOLD_LEN  = 300;
	localparam int          DRAIN_LEN = 16;

	// Scoreboard: convert each accepted HSV transfer into the RGB pixel it
	// must produce, then match output transfers against those in order.
	class pixel_scoreboard;
		rgb_t        rgb_q[$];
		int unsigned errors;

		// Clamp a saturation or brightness fraction to one.
		function logic [63:0] clamp_unit(frac_t x);
			return (64'(x) > UNIT) ? UNIT : 64'(x);
		endfunction

		// Blend channel c with white by s, scale by v and 255, truncate.
		function chan8_t blend_channel(logic [63:0] c, logic [63:0] s,
				logic [63:0] v);
			logic [63:0] mixed;
			logic [63:0] scaled;
			mixed  = s * c + (UNIT - s) * UNIT;
			scaled = mixed * v * 64'd255;
			return scaled[55:48];
		endfunction

		function rgb_t hsv_to_rgb(frac_t hue_in, frac_t sat_in, frac_t bri_in);
			logic [63:0] h;
			logic [63:0] s;
			logic [63:0] v;
			logic [63:0] t;
			logic [63:0] cr;
			logic [63:0] cg;
			logic [63:0] cb;
			rgb_t        px;
			h = 64'(hue_in);
			if (h > UNIT)
				h = h & 64'hFFFF;
			s = clamp_unit(sat_in);
			v = clamp_unit(bri_in);
			t = 64'd6 * h;
			if (t <= UNIT) begin
				cr = UNIT;     cg = t;            cb = 0;
			end else if (t <= 2 * UNIT) begin
				cg = UNIT;     cr = 2 * UNIT - t; cb = 0;
			end else if (t <= 3 * UNIT) begin
				cg = UNIT;     cb = t - 2 * UNIT; cr = 0;
			end else if (t <= 4 * UNIT) begin
				cb = UNIT;     cg = 4 * UNIT - t; cr = 0;
			end else if (t <= 5 * UNIT) begin
				cb = UNIT;     cr = t - 4 * UNIT; cg = 0;
			end else begin
				cr = UNIT;     cb = 6 * UNIT - t; cg = 0;
			end
			px.r = blend_channel(cr, s, v);
			px.g = blend_channel(cg, s, v);
			px.b = blend_channel(cb, s, v);
			return px;
		endfunction

		function void note_pixel(frac_t h, frac_t s, frac_t v);
			rgb_q.push_back(hsv_to_rgb(h, s, v));
		endfunction

		function void check_pixel(chan8_t r, chan8_t g, chan8_t b);
			rgb_t want;
			if (rgb_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%0t: output pixel %0d/%0d/%0d with none expected",
						$realtime, r, g, b);
				return;
			end
			want = rgb_q.pop_front();
			if (want.r !== r || want.g !== g || want.b !== b) begin
				errors++;
				if (errors <= 10)
					$display("%0t: pixel mismatch, expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
						$realtime, want.r, want.g, want.b, r, g, b);
			end
		endfunction

		function int pending();
			return rgb_q.size();
		endfunction
	endclass

	logic   clk;
	logic   arst_n;
	logic   in_valid;
	logic   in_ready;
	frac_t  hue;
	frac_t  saturation;
	frac_t  brightness;
	logic   out_valid;
	logic   out_ready;
	chan8_t red;
	chan8_t green;
	chan8_t blue;

	// Idle rates in percent, changed per phase.
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;

	// Long receiver hold-off, requested by the stimulus and timed on its own.
	logic hold_go;
	logic hold_off;

	pixel_scoreboard sb = new;

	hsv_to_rgb_pixel_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.hue        (hue),
		.saturation (saturation),
		.brightness (brightness),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.red        (red),
		.green      (green),
		.blue       (blue)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Receiver: check every output transfer, then pick the next ready value.
	// Ready is sampled before this edge's update, so the check sees the value
	// that the block saw.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_pixel(red, green, blue);
		out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
	end

	// Hold the output off for a fixed stretch once requested, so the pipeline
	// fills and in_ready drops while the sender keeps offering pixels.
	initial begin
		hold_off <= 1'b0;
		wait (hold_go === 1'b1);
		hold_off <= 1'b1;
		repeat (HOLD_LEN) @(posedge clk);
		hold_off <= 1'b0;
	end

	// Offer one pixel after a random idle gap; return once it transfers.
	// Valid stays high from one pixel to the next when no gap is drawn.
	task automatic send_pixel(input frac_t h, input frac_t s, input frac_t v);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		hue        <= h;
		saturation <= s;
		brightness <= v;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_pixel(h, s, v);
	endtask

	// Fraction for saturation or brightness: mostly in range, some above one
	// (clamped by the block), some pinned to the ends.
	function automatic frac_t rand_level();
		case ($urandom_range(9))
			6, 7:    return frac_t'($urandom());
			8:       return FRAC_ONE;
			9:       return '0;
			default: return frac_t'($urandom_range(65536));
		endcase
	endfunction

	// Hue: mostly one turn, some wrapping, some right at a sector edge.
	function automatic frac_t rand_hue();
		int unsigned edge_at;
		case ($urandom_range(9))
			7, 8: return frac_t'($urandom());
			9: begin
				edge_at = ($urandom_range(6) * 65536) / 6;
				return frac_t'(edge_at + $urandom_range(2)) - frac_t'(1);
			end
			default: return frac_t'($urandom_range(65536));
		endcase
	endfunction

	task automatic send_random(input int n);
		repeat (n)
			send_pixel(rand_hue(), rand_level(), rand_level());
	endtask

	initial begin
		arst_n         <= 1'b0;
		in_valid       <= 1'b0;
		hue            <= '0;
		saturation     <= '0;
		brightness     <= '0;
		out_ready      <= 1'b0;
		hold_go        <= 1'b0;
		send_idle_pct  <= 0;
		recv_stall_pct <= 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: pure hues, hue wrap above one turn, both sides of every sector
		// edge but half a turn, and saturation and brightness at zero, one and beyond.
		send_pixel(17'd0, FRAC_ONE, FRAC_ONE);
		send_pixel(FRAC_ONE, FRAC_ONE, FRAC_ONE);
		send_pixel(FRAC_ONE + 17'd1, FRAC_ONE, FRAC_ONE);
		send_pixel(FRAC_MAX, FRAC_ONE, FRAC_ONE);
		send_pixel(17'd65535, FRAC_ONE, FRAC_ONE);
		send_pixel(17'd10922, FRAC_ONE, FRAC_ONE);
		send_pixel(17'd10923, FRAC_ONE, FRAC_ONE);
		send_pixel(17'd21845, FRAC_ONE, FRAC_ONE);
		send_pixel(17'd21846, FRAC_ONE, FRAC_ONE);
		send_pixel(17'd32768, FRAC_ONE, FRAC_ONE);
		send_pixel(17'd43690, FRAC_ONE, FRAC_ONE);
		send_pixel(17'd43691, FRAC_ONE, FRAC_ONE);
		send_pixel(17'd54613, FRAC_ONE, FRAC_ONE);
		send_pixel(17'd54614, FRAC_ONE, FRAC_ONE);
		send_pixel(17'd20000, 17'd0, FRAC_ONE);
		send_pixel(17'd30000, FRAC_ONE + 17'd1, 17'd65535);
		send_pixel(17'd40000, FRAC_MAX, FRAC_MAX);
		send_pixel(17'd50000, FRAC_ONE, 17'd0);
		send_pixel(17'd60000, 17'd32768, FRAC_ONE + 17'd1);
		send_pixel(17'd0, 17'd0, 17'd0);
		send_pixel(FRAC_MAX, FRAC_MAX, FRAC_MAX);
		send_pixel(17'd1, 17'd1, 17'd1);

		// Full rate on both sides.
		send_random(320);

		// Stall the output for a long stretch while pixels keep coming.
		hold_go <= 1'b1;
		send_random(40);

		// Sparse input.
		send_idle_pct <= 79;
		send_random(320);

		// Heavy output back-pressure with a steady sender.
		send_idle_pct  <= 0;
		recv_stall_pct <= 79;
		send_random(320);

		// Light gaps on both sides.
		send_idle_pct  <= 18;
		recv_stall_pct <= 18;
		send_random(330);

		in_valid       <= 1'b0;
		recv_stall_pct <= 0;

		// Drain, then keep watching for anything unexpected to appear.
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_LEN) @(posedge clk);

		if (sb.errors == 0 && sb.pending() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#2_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule
